>>> rtl/core/dltq_pkg.sv
// Package for the delta-list timeout queue: sizes, codes, item and
// memory word types shared by the controller and the testbench.
// No dependencies.
`default_nettype none
package dltq_pkg;

	localparam int NUM_ENTRIES = 16;
	localparam int TICK_BITS   = 16;
	localparam int LINK_W      = $clog2(NUM_ENTRIES + 1);
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int WORD_W      = TICK_BITS + 2 * LINK_W;

	typedef logic [TICK_BITS-1:0] tick_t;
	typedef logic [LINK_W-1:0]    link_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [3:0]           id_t;

	localparam link_t NIL_LINK = link_t'(NUM_ENTRIES);
	localparam logic [32:0] TICK_MAX = (33'd1 << TICK_BITS) - 33'd1;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_CANCEL = 2'd1,
		MODE_TICK   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_TIME   = 2'd1,
		ST_NOT_LINKED = 2'd2,
		ST_DUP_LINK   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  entry_id;
		logic [15:0] timeout_ticks;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic       expired_valid;
		logic [3:0] expired_id;
		logic       last;
	} result_t;

	typedef struct packed {
		tick_t delta;
		link_t next;
		link_t prev;
	} word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RESP,
		S_INS_RD,
		S_INS_CHK,
		S_INS_WE,
		S_INS_WC,
		S_INS_WP,
		S_CAN_RE,
		S_CAN_GE,
		S_CAN_RN,
		S_CAN_GN,
		S_CAN_RP,
		S_CAN_GP,
		S_CAN_FIN,
		S_TICK_RH,
		S_TICK_GH
	} state_t;

	typedef enum logic [1:0] {
		P_NONE,
		P_POP,
		P_NEXT
	} pop_t;

	// link points at a real entry
	function automatic logic link_ok(link_t l);
		return 32'(l) < NUM_ENTRIES;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/dltq_ram.sv
// Generic single write, single read RAM with registered read data.
// Standalone; used for the entry table of the timeout queue.
`default_nettype none
module dltq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/delta_list_timeout_queue.sv
// Delta-list timeout queue: one item per command, results on a one-cycle strobe.
// Insert walks the list reading one entry at a time; cancel reads the entry and then
// updates each neighbor; tick decrements the head and pops each expired entry;
// rejects and the unused mode respond directly.
// Throughput: one item at a time; busy drops while the last result is shown.
// Reset clears links and head and sets max_period to 65535; no RAM clearing pass.
// The receiver cannot stall; each result is shown for one cycle.
`default_nettype none
module delta_list_timeout_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire dltq_pkg::cmd_t   cmd,
	output logic                  done,
	output dltq_pkg::result_t     result,
	input  wire logic             cfg_we,
	input  wire logic [15:0]      cfg_data
);

	dltq_pkg::state_t state_q, state_d;
	dltq_pkg::pop_t   pop_q, pop_d;
	dltq_pkg::link_t  e_q, cur_q, prv_q, hid_q, head_q;
	dltq_pkg::tick_t  d_q;
	dltq_pkg::word_t  cw_q, pw_q, rd;
	logic [1:0]       st_q;
	logic [15:0]      maxp_q;
	logic [dltq_pkg::NUM_ENTRIES-1:0] linked_q;
	logic             done_q;
	dltq_pkg::result_t res_q;

	logic             ram_we, ram_re;
	dltq_pkg::link_t  ram_waddr, ram_raddr;
	dltq_pkg::word_t  ram_wdata;
	logic [dltq_pkg::WORD_W-1:0] ram_rdata;
	logic             emit;
	dltq_pkg::result_t emit_res;

	logic             accept, t_bad, e_ok, e_linked;
	dltq_pkg::tick_t  dnew;
	logic [dltq_pkg::TICK_BITS:0] csum;
	dltq_pkg::tick_t  csat;

	assign accept   = start && !busy;
	assign busy     = (state_q != dltq_pkg::S_IDLE) || (pop_q != dltq_pkg::P_NONE);
	assign rd       = dltq_pkg::word_t'(ram_rdata);
	assign t_bad    = (cmd.timeout_ticks == 16'd0) || (cmd.timeout_ticks > maxp_q)
		|| ({17'd0, cmd.timeout_ticks} > dltq_pkg::TICK_MAX);
	assign e_ok     = 32'(cmd.entry_id) < dltq_pkg::NUM_ENTRIES;
	assign e_linked = linked_q[dltq_pkg::idx_t'(cmd.entry_id)];
	assign dnew     = (rd.delta != '0) ? rd.delta - 1'b1 : rd.delta;
	assign csum     = {1'b0, rd.delta} + {1'b0, cw_q.delta};
	assign csat     = csum[dltq_pkg::TICK_BITS] ? '1 : csum[dltq_pkg::TICK_BITS-1:0];

	dltq_ram #(
		.WIDTH(dltq_pkg::WORD_W),
		.DEPTH(dltq_pkg::NUM_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr[dltq_pkg::IDX_W-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr[dltq_pkg::IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		pop_d   = pop_q;
		if (pop_q == dltq_pkg::P_POP) begin
			pop_d = dltq_pkg::link_ok(cw_q.next) ? dltq_pkg::P_NEXT : dltq_pkg::P_NONE;
		end else if (pop_q == dltq_pkg::P_NEXT) begin
			pop_d = (rd.delta == '0) ? dltq_pkg::P_POP : dltq_pkg::P_NONE;
		end else begin
			unique case (state_q)
				dltq_pkg::S_IDLE: begin
					if (accept) begin
						unique case (dltq_pkg::mode_t'(cmd.mode))
							dltq_pkg::MODE_INSERT:
								state_d = (t_bad || !e_ok || e_linked) ?
									dltq_pkg::S_RESP : dltq_pkg::S_INS_RD;
							dltq_pkg::MODE_CANCEL:
								state_d = (!e_ok || !e_linked) ?
									dltq_pkg::S_RESP : dltq_pkg::S_CAN_RE;
							dltq_pkg::MODE_TICK: state_d = dltq_pkg::S_TICK_RH;
							default:             state_d = dltq_pkg::S_RESP;
						endcase
					end
				end
				dltq_pkg::S_RESP:    state_d = dltq_pkg::S_IDLE;
				dltq_pkg::S_INS_RD:
					state_d = dltq_pkg::link_ok(cur_q) ? dltq_pkg::S_INS_CHK
						: dltq_pkg::S_INS_WE;
				dltq_pkg::S_INS_CHK:
					state_d = (rd.delta < d_q) ? dltq_pkg::S_INS_RD : dltq_pkg::S_INS_WE;
				dltq_pkg::S_INS_WE:  state_d = dltq_pkg::S_INS_WC;
				dltq_pkg::S_INS_WC:  state_d = dltq_pkg::S_INS_WP;
				dltq_pkg::S_INS_WP:  state_d = dltq_pkg::S_IDLE;
				dltq_pkg::S_CAN_RE:  state_d = dltq_pkg::S_CAN_GE;
				dltq_pkg::S_CAN_GE:  state_d = dltq_pkg::S_CAN_RN;
				dltq_pkg::S_CAN_RN:
					state_d = dltq_pkg::link_ok(cw_q.next) ? dltq_pkg::S_CAN_GN
						: dltq_pkg::S_CAN_RP;
				dltq_pkg::S_CAN_GN:  state_d = dltq_pkg::S_CAN_RP;
				dltq_pkg::S_CAN_RP:
					state_d = dltq_pkg::link_ok(cw_q.prev) ? dltq_pkg::S_CAN_GP
						: dltq_pkg::S_CAN_FIN;
				dltq_pkg::S_CAN_GP:  state_d = dltq_pkg::S_CAN_FIN;
				dltq_pkg::S_CAN_FIN: state_d = dltq_pkg::S_IDLE;
				dltq_pkg::S_TICK_RH:
					state_d = dltq_pkg::link_ok(head_q) ? dltq_pkg::S_TICK_GH
						: dltq_pkg::S_RESP;
				dltq_pkg::S_TICK_GH: begin
					state_d = dltq_pkg::S_IDLE;
					if (dnew == '0) begin
						pop_d = dltq_pkg::P_POP;
					end
				end
				default: state_d = dltq_pkg::S_IDLE;
			endcase
		end
	end

	// RAM access and result emission
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = cw_q;
		ram_re    = 1'b0;
		ram_raddr = cur_q;
		emit      = 1'b0;
		emit_res  = '{status: st_q, expired_valid: 1'b0, expired_id: 4'd0, last: 1'b1};
		if (pop_q == dltq_pkg::P_POP) begin
			ram_re    = dltq_pkg::link_ok(cw_q.next);
			ram_raddr = cw_q.next;
			if (!dltq_pkg::link_ok(cw_q.next)) begin
				emit     = 1'b1;
				emit_res = '{status: dltq_pkg::ST_OK, expired_valid: 1'b1,
					expired_id: dltq_pkg::id_t'(hid_q), last: 1'b1};
			end
		end else if (pop_q == dltq_pkg::P_NEXT) begin
			ram_we    = 1'b1;
			ram_waddr = cw_q.next;
			ram_wdata = '{delta: rd.delta, next: rd.next, prev: dltq_pkg::NIL_LINK};
			emit      = 1'b1;
			emit_res  = '{status: dltq_pkg::ST_OK, expired_valid: 1'b1,
				expired_id: dltq_pkg::id_t'(hid_q), last: (rd.delta != '0)};
		end else begin
			unique case (state_q)
				dltq_pkg::S_RESP: emit = 1'b1;
				dltq_pkg::S_INS_RD: begin
					ram_re    = dltq_pkg::link_ok(cur_q);
					ram_raddr = cur_q;
				end
				dltq_pkg::S_INS_WE: begin
					ram_we    = 1'b1;
					ram_waddr = e_q;
					ram_wdata = '{delta: d_q, next: cur_q, prev: prv_q};
				end
				dltq_pkg::S_INS_WC: begin
					ram_we    = dltq_pkg::link_ok(cur_q);
					ram_waddr = cur_q;
					ram_wdata = '{delta: cw_q.delta - d_q, next: cw_q.next, prev: e_q};
				end
				dltq_pkg::S_INS_WP: begin
					ram_we    = dltq_pkg::link_ok(prv_q);
					ram_waddr = prv_q;
					ram_wdata = '{delta: pw_q.delta, next: e_q, prev: pw_q.prev};
					emit      = 1'b1;
				end
				dltq_pkg::S_CAN_RE: begin
					ram_re    = 1'b1;
					ram_raddr = e_q;
				end
				dltq_pkg::S_CAN_RN: begin
					ram_re    = dltq_pkg::link_ok(cw_q.next);
					ram_raddr = cw_q.next;
				end
				dltq_pkg::S_CAN_GN: begin
					ram_we    = 1'b1;
					ram_waddr = cw_q.next;
					ram_wdata = '{delta: csat, next: rd.next, prev: cw_q.prev};
				end
				dltq_pkg::S_CAN_RP: begin
					ram_re    = dltq_pkg::link_ok(cw_q.prev);
					ram_raddr = cw_q.prev;
				end
				dltq_pkg::S_CAN_GP: begin
					ram_we    = 1'b1;
					ram_waddr = cw_q.prev;
					ram_wdata = '{delta: rd.delta, next: cw_q.next, prev: rd.prev};
				end
				dltq_pkg::S_CAN_FIN: emit = 1'b1;
				dltq_pkg::S_TICK_RH: begin
					ram_re    = dltq_pkg::link_ok(head_q);
					ram_raddr = head_q;
				end
				dltq_pkg::S_TICK_GH: begin
					if (dnew != '0) begin
						ram_we    = 1'b1;
						ram_waddr = head_q;
						ram_wdata = '{delta: dnew, next: rd.next, prev: rd.prev};
						emit      = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// control state, list head and link flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dltq_pkg::S_IDLE;
			pop_q    <= dltq_pkg::P_NONE;
			head_q   <= dltq_pkg::NIL_LINK;
			linked_q <= '0;
			maxp_q   <= 16'hFFFF;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			pop_q   <= pop_d;
			done_q  <= emit;
			if (cfg_we) begin
				maxp_q <= cfg_data;
			end
			if (pop_q == dltq_pkg::P_POP) begin
				linked_q[hid_q[dltq_pkg::IDX_W-1:0]] <= 1'b0;
				if (!dltq_pkg::link_ok(cw_q.next)) begin
					head_q <= dltq_pkg::NIL_LINK;
				end
			end else if (pop_q == dltq_pkg::P_NEXT) begin
				head_q <= cw_q.next;
			end else if (state_q == dltq_pkg::S_INS_WP) begin
				linked_q[e_q[dltq_pkg::IDX_W-1:0]] <= 1'b1;
				if (!dltq_pkg::link_ok(prv_q)) begin
					head_q <= e_q;
				end
			end else if (state_q == dltq_pkg::S_CAN_FIN) begin
				linked_q[e_q[dltq_pkg::IDX_W-1:0]] <= 1'b0;
				if (!dltq_pkg::link_ok(cw_q.prev)) begin
					head_q <= cw_q.next;
				end
			end
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_res;
		end
		if (pop_q == dltq_pkg::P_NEXT) begin
			// advance the pop to the new head
			if (rd.delta == '0) begin
				cw_q  <= rd;
				hid_q <= cw_q.next;
			end
		end else if (pop_q == dltq_pkg::P_NONE) begin
			unique case (state_q)
				dltq_pkg::S_IDLE: begin
					e_q   <= dltq_pkg::link_t'(cmd.entry_id);
					d_q   <= dltq_pkg::tick_t'(cmd.timeout_ticks);
					cur_q <= head_q;
					prv_q <= dltq_pkg::NIL_LINK;
					st_q  <= dltq_pkg::ST_OK;
					if (cmd.mode == dltq_pkg::MODE_INSERT) begin
						if (t_bad) begin
							st_q <= dltq_pkg::ST_BAD_TIME;
						end else if (!e_ok) begin
							st_q <= dltq_pkg::ST_NOT_LINKED;
						end else if (e_linked) begin
							st_q <= dltq_pkg::ST_DUP_LINK;
						end
					end else if (cmd.mode == dltq_pkg::MODE_CANCEL) begin
						if (!e_ok || !e_linked) begin
							st_q <= dltq_pkg::ST_NOT_LINKED;
						end
					end
				end
				dltq_pkg::S_INS_CHK: begin
					// step past entries that expire strictly earlier
					if (rd.delta < d_q) begin
						d_q   <= d_q - rd.delta;
						pw_q  <= rd;
						prv_q <= cur_q;
						cur_q <= rd.next;
					end else begin
						cw_q <= rd;
					end
				end
				dltq_pkg::S_CAN_GE: cw_q <= rd;
				dltq_pkg::S_TICK_GH: begin
					cw_q  <= rd;
					hid_q <= head_q;
				end
				default: ;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// every accepted item makes the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// the final result of an item frees the block
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.last |-> !busy)
		else $error("busy after last result");

	// more results pending keep the block busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last |-> busy && result.expired_valid)
		else $error("non-final result outside a tick pop");

	// expiry results always carry ok status
	a_exp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.expired_valid |-> result.status == dltq_pkg::ST_OK)
		else $error("expired entry with error status");

endmodule
`default_nettype wire

>>> test/tb_delta_list_timeout_queue.sv
// Testbench for the delta-list timeout queue: directed and random commands
// checked against an in-bench model of the list. Depends on dltq_pkg and the DUT.
`timescale 1ns / 100ps
module tb_delta_list_timeout_queue;
	import dltq_pkg::*;

	localparam int WATCH_LIMIT = 20000;
	localparam int RAND_ITEMS  = 420;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        done;
	result_t     result;
	logic        cfg_we;
	logic [15:0] cfg_data;

	// model state
	logic [15:0] m_delta [NUM_ENTRIES];
	int          m_next  [NUM_ENTRIES];
	int          m_prev  [NUM_ENTRIES];
	bit          m_linked[NUM_ENTRIES];
	int          m_head;
	logic [15:0] m_max_period;

	cmd_t    pending_cmds[$];
	result_t expected_results[$];
	int      fail_count;
	int      idle_cycles;
	int      gap_left;
	bit      no_gaps;

	delta_list_timeout_queue u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic result_t mk_result(status_t st, bit ev, int id, bit lst);
		result_t r;
		r.status        = st;
		r.expired_valid = ev;
		r.expired_id    = id[3:0];
		r.last          = lst;
		return r;
	endfunction

	// unlink one entry, folding its delta into its successor
	task automatic unlink_entry(int e);
		int n;
		int p;
		logic [16:0] s;
		n = m_next[e];
		p = m_prev[e];
		if (n < NUM_ENTRIES) begin
			s = {1'b0, m_delta[n]} + {1'b0, m_delta[e]};
			m_delta[n] = s[16] ? 16'hFFFF : s[15:0];
			m_prev[n] = p;
		end
		if (p < NUM_ENTRIES)
			m_next[p] = n;
		else
			m_head = n;
		m_next[e] = NUM_ENTRIES;
		m_prev[e] = NUM_ENTRIES;
		m_linked[e] = 1'b0;
	endtask

	// sort an entry in ahead of equal deadlines
	task automatic link_entry(int e, logic [15:0] d);
		int cur;
		int prv;
		int guard;
		cur = m_head;
		prv = NUM_ENTRIES;
		guard = 0;
		while (cur < NUM_ENTRIES && guard < NUM_ENTRIES && m_delta[cur] < d) begin
			d -= m_delta[cur];
			prv = cur;
			cur = m_next[cur];
			guard++;
		end
		m_delta[e] = d;
		m_next[e] = cur;
		m_prev[e] = prv;
		if (cur < NUM_ENTRIES) begin
			m_delta[cur] -= d;
			m_prev[cur] = e;
		end
		if (prv < NUM_ENTRIES)
			m_next[prv] = e;
		else
			m_head = e;
		m_linked[e] = 1'b1;
	endtask

	// compute the results of one command and queue them
	task automatic predict_queue(cmd_t c);
		int e;
		int k;
		result_t r;
		e = c.entry_id;
		k = 0;
		case (mode_t'(c.mode))
			MODE_INSERT: begin
				if (c.timeout_ticks == 0 || c.timeout_ticks > m_max_period)
					expected_results.push_back(mk_result(ST_BAD_TIME, 0, 0, 1));
				else if (m_linked[e])
					expected_results.push_back(mk_result(ST_DUP_LINK, 0, 0, 1));
				else begin
					link_entry(e, c.timeout_ticks);
					expected_results.push_back(mk_result(ST_OK, 0, 0, 1));
				end
			end
			MODE_CANCEL: begin
				if (!m_linked[e])
					expected_results.push_back(mk_result(ST_NOT_LINKED, 0, 0, 1));
				else begin
					unlink_entry(e);
					expected_results.push_back(mk_result(ST_OK, 0, 0, 1));
				end
			end
			MODE_TICK: begin
				if (m_head < NUM_ENTRIES && m_delta[m_head] > 0)
					m_delta[m_head] -= 1;
				while (m_head < NUM_ENTRIES && k < NUM_ENTRIES && m_delta[m_head] == 0) begin
					r = mk_result(ST_OK, 1, m_head, 0);
					unlink_entry(m_head);
					expected_results.push_back(r);
					k++;
				end
				if (k == 0)
					expected_results.push_back(mk_result(ST_OK, 0, 0, 1));
				else begin
					r = expected_results.pop_back();
					r.last = 1'b1;
					expected_results.push_back(r);
				end
			end
			default: expected_results.push_back(mk_result(ST_OK, 0, 0, 1));
		endcase
	endtask

	// driver: issue pending items with random gaps unless no_gaps is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap_left <= 0;
		end else if (start && !busy) begin
			predict_queue(cmd);
			if (!no_gaps && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				gap_left <= $urandom_range(1, 12);
			end else if (pending_cmds.size() > 0) begin
				cmd <= pending_cmds.pop_front();
			end else begin
				start <= 1'b0;
			end
		end else if (!start) begin
			if (gap_left > 0)
				gap_left <= gap_left - 1;
			else if (pending_cmds.size() > 0) begin
				cmd <= pending_cmds.pop_front();
				start <= 1'b1;
			end
		end
	end

	// monitor: compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result %h", result);
				fail_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.status !== exp_r.status) begin
					$error("status expected %0d actual %0d", exp_r.status, result.status);
					fail_count++;
				end
				if (result.expired_valid !== exp_r.expired_valid) begin
					$error("expired_valid expected %0d actual %0d",
						exp_r.expired_valid, result.expired_valid);
					fail_count++;
				end
				if (result.expired_id !== exp_r.expired_id) begin
					$error("expired_id expected %0d actual %0d",
						exp_r.expired_id, result.expired_id);
					fail_count++;
				end
				if (result.last !== exp_r.last) begin
					$error("last expected %0d actual %0d", exp_r.last, result.last);
					fail_count++;
				end
			end
		end
	end

	// watchdog: count cycles with no handshake
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCH_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic cmd_t mk_cmd(mode_t md, int id, int t);
		cmd_t c;
		c.mode = md;
		c.entry_id = id[3:0];
		c.timeout_ticks = t[15:0];
		return c;
	endfunction

	task automatic drain();
		wait (pending_cmds.size() == 0 && !start);
		while (expected_results.size() > 0 || busy)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_max_period(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		m_max_period = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random phase: mostly inserts and ticks with short timeouts
	task automatic random_phase(int n, int tmax);
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				pending_cmds.push_back(mk_cmd(MODE_INSERT, $urandom_range(0, 15),
					($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, tmax)));
			else if (sel < 55)
				pending_cmds.push_back(mk_cmd(MODE_CANCEL, $urandom_range(0, 15), $urandom));
			else if (sel < 97)
				pending_cmds.push_back(mk_cmd(MODE_TICK, $urandom_range(0, 15), $urandom));
			else
				pending_cmds.push_back(mk_cmd(MODE_NONE, $urandom_range(0, 15), $urandom));
		end
	endtask

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 16'hFFFF;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			m_delta[i] = '0;
			m_next[i] = NUM_ENTRIES;
			m_prev[i] = NUM_ENTRIES;
			m_linked[i] = 1'b0;
		end
		m_head = NUM_ENTRIES;
		m_max_period = 16'hFFFF;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, bad timeouts, duplicates, equal deadlines, overflow
		pending_cmds.push_back(mk_cmd(MODE_TICK, 0, 0));
		pending_cmds.push_back(mk_cmd(MODE_INSERT, 3, 0));
		pending_cmds.push_back(mk_cmd(MODE_CANCEL, 3, 0));
		pending_cmds.push_back(mk_cmd(MODE_NONE, 15, 16'hFFFF));
		pending_cmds.push_back(mk_cmd(MODE_INSERT, 15, 16'hFFFF));
		pending_cmds.push_back(mk_cmd(MODE_INSERT, 0, 16'hFFFF));
		pending_cmds.push_back(mk_cmd(MODE_INSERT, 15, 5));
		pending_cmds.push_back(mk_cmd(MODE_CANCEL, 15, 0));
		pending_cmds.push_back(mk_cmd(MODE_INSERT, 1, 2));
		pending_cmds.push_back(mk_cmd(MODE_INSERT, 2, 2));
		pending_cmds.push_back(mk_cmd(MODE_INSERT, 4, 1));
		pending_cmds.push_back(mk_cmd(MODE_TICK, 0, 0));
		pending_cmds.push_back(mk_cmd(MODE_TICK, 0, 0));
		pending_cmds.push_back(mk_cmd(MODE_INSERT, 5, 1));
		pending_cmds.push_back(mk_cmd(MODE_INSERT, 6, 1));
		pending_cmds.push_back(mk_cmd(MODE_TICK, 0, 0));
		pending_cmds.push_back(mk_cmd(MODE_CANCEL, 0, 0));
		pending_cmds.push_back(mk_cmd(MODE_CANCEL, 0, 0));
		drain();

		write_max_period(16'd1);
		pending_cmds.push_back(mk_cmd(MODE_INSERT, 7, 2));
		pending_cmds.push_back(mk_cmd(MODE_INSERT, 7, 1));
		pending_cmds.push_back(mk_cmd(MODE_TICK, 0, 0));
		random_phase(60, 2);
		drain();

		write_max_period(16'd12);
		random_phase(180, 14);
		drain();

		write_max_period(16'd40);
		random_phase(100, 45);
		drain();

		// last part without gaps
		write_max_period(16'hFFFF);
		no_gaps = 1'b1;
		random_phase(80, 20);
		drain();

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
